@@ rtl/humidity_temp_decode_moving_average_defines.svh @@
// ---------------------------------------------------------------------------
// humidity/temperature decoder assertion macros
// shared concurrent assertion forms, sampled on clk_i
// ---------------------------------------------------------------------------
`ifndef HUMIDITY_TEMP_DECODE_MOVING_AVERAGE_DEFINES_SVH
`define HUMIDITY_TEMP_DECODE_MOVING_AVERAGE_DEFINES_SVH

// checked only outside reset
`define HMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define HMD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/hmd_pkg.sv @@
// ---------------------------------------------------------------------------
// hmd_pkg
// widths, scale constants and shared types of the humidity/temperature decoder
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package hmd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CODE_W    = 20;
  localparam int unsigned HUM_W     = 14;
  localparam int unsigned TEMP_W    = 15;
  localparam int unsigned CNT_OUT_W = 7;
  localparam int unsigned MUL_B_W   = 15;
  localparam int unsigned PROD_W    = CODE_W + MUL_B_W;
  localparam int unsigned CODE_SHIFT = 20;
  localparam int unsigned DEPTH_DEF = 64;

  localparam logic [MUL_B_W-1:0] HUM_SCALE  = 15'd10000;
  localparam logic [MUL_B_W-1:0] TEMP_SCALE = 15'd20000;
  localparam logic [TEMP_W:0]    TEMP_OFFSET = 16'd5000;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

@@ rtl/humidity_temp_decode_moving_average.sv @@
// ---------------------------------------------------------------------------
// humidity_temp_decode_moving_average
// sensor reply decoder with a boxcar average of the last DEPTH temperatures
// ---------------------------------------------------------------------------
// Each input word is the five measurement bytes of a sensor reply; one result
// word follows with humidity in hundredths of a percent, temperature in
// hundredths of a degree, the truncated-toward-zero average of the held
// temperatures and the sample count. From accept to result a word makes two
// passes through the shared multiplier, a running-sum update in the S_SUB and
// S_ADD states, and goes through a serial divider that produces one quotient
// bit per cycle over 14 + clog2(DEPTH) bits. The next word is accepted the
// cycle after the result is loaded into the output register, even while that
// result is still stalled. The history memory needs no clearing pass: old
// entries are subtracted only once the ring has been filled.
`timescale 1ns / 1ps

`include "humidity_temp_decode_moving_average_defines.svh"

module humidity_temp_decode_moving_average #(
  parameter int unsigned DEPTH = hmd_pkg::DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [hmd_pkg::BYTE_W-1:0]           hum_high_byte_i,
  input  logic [hmd_pkg::BYTE_W-1:0]           hum_mid_byte_i,
  input  logic [hmd_pkg::BYTE_W-1:0]           shared_byte_i,
  input  logic [hmd_pkg::BYTE_W-1:0]           temp_mid_byte_i,
  input  logic [hmd_pkg::BYTE_W-1:0]           temp_low_byte_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [hmd_pkg::HUM_W-1:0]            humidity_centipct_o,
  output logic signed [hmd_pkg::TEMP_W-1:0]    temp_centideg_o,
  output logic signed [hmd_pkg::TEMP_W-1:0]    avg_centideg_o,
  output logic [hmd_pkg::CNT_OUT_W-1:0]        samples_held_o
);

  import hmd_pkg::*;

  localparam int unsigned SLOT_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W  = TEMP_W + $clog2(DEPTH);
  localparam int unsigned MAG_W  = SUM_W - 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HUM,
    S_TMP,
    S_SUB,
    S_ADD,
    S_GO,
    S_DIV,
    S_DONE
  } state_e;

  state_e state_q;

  logic [CODE_W-1:0]       hum_code_q;
  logic [CODE_W-1:0]       temp_code_q;
  logic [HUM_W-1:0]        hum_q;
  logic [TEMP_W-1:0]       temp_q;
  logic signed [SUM_W-1:0] total_q;
  logic [SLOT_W-1:0]       slot_q;
  logic [CNT_W-1:0]        fill_q;

  logic                    out_valid_q;
  logic [HUM_W-1:0]        out_hum_q;
  logic [TEMP_W-1:0]       out_temp_q;
  logic [TEMP_W-1:0]       out_avg_q;
  logic [CNT_W-1:0]        out_fill_q;

  logic                    accept;
  logic                    out_free;
  logic                    mul_en;
  logic [CODE_W-1:0]       mul_a;
  logic [MUL_B_W-1:0]      mul_b;
  logic [PROD_W-1:0]       prod;
  logic [TEMP_W:0]         temp_ofs;
  logic [TEMP_W-1:0]       old_temp;
  logic                    ring_we;
  logic                    div_start;
  logic [SUM_W-1:0]        total_abs;
  logic [MAG_W-1:0]        quo;
  logic [MAG_W-1:0]        avg_mag;
  div_status_t             div_st;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  assign mul_en = (state_q == S_HUM) || (state_q == S_TMP);
  assign mul_a  = (state_q == S_HUM) ? hum_code_q : temp_code_q;
  assign mul_b  = (state_q == S_HUM) ? HUM_SCALE : TEMP_SCALE;

  hmd_mul #(
    .AW(CODE_W),
    .BW(MUL_B_W)
  ) u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .prod_o(prod)
  );

  assign ring_we = (state_q == S_ADD);

  hmd_ring #(
    .DEPTH(DEPTH),
    .AW   (SLOT_W),
    .DW   (TEMP_W)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ring_we),
    .waddr_i(slot_q),
    .wdata_i(temp_q),
    .re_i   (accept),
    .raddr_i(slot_q),
    .rdata_o(old_temp)
  );

  // temperature code scaled and shifted down, then the offset subtracted
  assign temp_ofs = {1'b0, prod[CODE_SHIFT +: TEMP_W]} - TEMP_OFFSET;

  assign div_start = (state_q == S_GO);
  assign total_abs = total_q[SUM_W-1] ? -total_q : total_q;

  hmd_div #(
    .NUM_W(MAG_W),
    .DEN_W(CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (total_abs[MAG_W-1:0]),
    .den_i   (fill_q),
    .quo_o   (quo),
    .status_o(div_st)
  );

  assign avg_mag = total_q[SUM_W-1] ? -quo : quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hum_code_q  <= '0;
      temp_code_q <= '0;
      hum_q       <= '0;
      temp_q      <= '0;
      total_q     <= '0;
      slot_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      out_hum_q   <= '0;
      out_temp_q  <= '0;
      out_avg_q   <= '0;
      out_fill_q  <= '0;
    end else begin
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            hum_code_q  <= {hum_high_byte_i, hum_mid_byte_i, shared_byte_i[7:4]};
            temp_code_q <= {shared_byte_i[3:0], temp_mid_byte_i, temp_low_byte_i};
            state_q     <= S_HUM;
          end
        end
        S_HUM: begin
          state_q <= S_TMP;
        end
        S_TMP: begin
          hum_q   <= prod[CODE_SHIFT +: HUM_W];
          state_q <= S_SUB;
        end
        S_SUB: begin
          temp_q <= temp_ofs[TEMP_W-1:0];
          // full ring: drop the oldest word before it is overwritten
          if (fill_q == CNT_W'(DEPTH)) begin
            total_q <= total_q - SUM_W'($signed(old_temp));
          end
          state_q <= S_ADD;
        end
        S_ADD: begin
          total_q <= total_q + SUM_W'($signed(temp_q));
          if (slot_q == SLOT_W'(DEPTH - 1)) begin
            slot_q <= '0;
          end else begin
            slot_q <= slot_q + SLOT_W'(1);
          end
          if (fill_q != CNT_W'(DEPTH)) begin
            fill_q <= fill_q + CNT_W'(1);
          end
          state_q <= S_GO;
        end
        S_GO: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_st.done) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_hum_q   <= hum_q;
            out_temp_q  <= temp_q;
            out_avg_q   <= avg_mag[TEMP_W-1:0];
            out_fill_q  <= fill_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o          = (state_q != S_IDLE);
  assign out_valid_o         = out_valid_q;
  assign humidity_centipct_o = out_hum_q;
  assign temp_centideg_o     = $signed(out_temp_q);
  assign avg_centideg_o      = $signed(out_avg_q);
  assign samples_held_o      = CNT_OUT_W'(out_fill_q);

  `HMD_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(state_q == S_DONE), "result word without finished division")
  `HMD_ASSERT(a_accept_starts, accept |=> (state_q == S_HUM), "accepted word did not start the sequence")
  `HMD_ASSERT_ALWAYS(a_div_idle, (state_q == S_IDLE) |-> !div_st.busy, "divider busy while block idle")
  `HMD_ASSERT(a_fill_range, (fill_q <= CNT_W'(DEPTH)) && (!out_valid_q || (out_fill_q != '0)), "fill count out of range")

endmodule

@@ rtl/hmd_mul.sv @@
// ---------------------------------------------------------------------------
// hmd_mul
// shared code-by-scale multiplier with a registered product
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hmd_mul #(
  parameter int unsigned AW = hmd_pkg::CODE_W,
  parameter int unsigned BW = hmd_pkg::MUL_B_W
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [AW-1:0] a_i,
  input  logic [BW-1:0] b_i,
  output logic [AW+BW-1:0] prod_o
);

  logic [AW+BW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= (AW+BW)'(a_i) * (AW+BW)'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

@@ rtl/hmd_ring.sv @@
// ---------------------------------------------------------------------------
// hmd_ring
// temperature history memory, one write and one registered read port
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hmd_ring #(
  parameter int unsigned DEPTH = hmd_pkg::DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned DW    = hmd_pkg::TEMP_W
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/hmd_div.sv @@
// ---------------------------------------------------------------------------
// hmd_div
// serial restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hmd_div #(
  parameter int unsigned NUM_W = hmd_pkg::CODE_W,
  parameter int unsigned DEN_W = hmd_pkg::CNT_OUT_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NUM_W-1:0]    num_i,
  input  logic [DEN_W-1:0]    den_i,
  output logic [NUM_W-1:0]    quo_o,
  output hmd_pkg::div_status_t status_o
);

  import hmd_pkg::*;

  localparam int unsigned CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;

  assign rem_sh = {rem_q, quo_q[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        quo_q  <= num_i;
        rem_q  <= '0;
        den_q  <= den_i;
        cnt_q  <= CW'(NUM_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        // top bit of diff set means the trial subtract borrowed
        if (!diff[DEN_W]) begin
          rem_q <= diff[DEN_W-1:0];
          quo_q <= {quo_q[NUM_W-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[DEN_W-1:0];
          quo_q <= {quo_q[NUM_W-2:0], 1'b0};
        end
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quo_o           = quo_q;
  assign status_o.busy   = busy_q;
  assign status_o.done   = done_q;

endmodule
